// File: hw/rtl/ite_pkg.sv
package ite_pkg;

   localparam int DEF_CAPACITY = 64;

   localparam int FUNC_W  = 3;
   localparam int KEY_W   = 17;
   localparam int QTY_W   = 16;
   localparam int ROW_W   = 6;
   localparam int STAT_W  = 3;
   localparam int TOTAL_W = 7;

   typedef enum logic [FUNC_W-1:0] {
      FN_INSERT = 3'd0,
      FN_FIND   = 3'd1,
      FN_REMOVE = 3'd2,
      FN_ADD    = 3'd3,
      FN_REDUCE = 3'd4,
      FN_SORT   = 3'd5,
      FN_SHIP   = 3'd6,
      FN_READ   = 3'd7
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_NONE      = 3'd4,
      ST_RANGE     = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_ROW_OUT,
      S_SORT_RD0,
      S_SORT_LD0,
      S_SORT_STEP,
      S_SORT_TAIL,
      S_SHIP_RD,
      S_SHIP_CMP,
      S_SHIP_END
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [QTY_W-1:0] have;
      logic [QTY_W-1:0] need;
   } entry_type;

endpackage

// File: hw/rtl/ite_table.sv
module ite_table
   import ite_pkg::*;
#(
   parameter int DEPTH = DEF_CAPACITY,
   parameter int AW    = $clog2(DEF_CAPACITY)
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [AW-1:0]   wr_addr,
   input  entry_type       wr_data,
   input  logic [AW-1:0]   rd_addr,
   output entry_type       rd_data
);

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/inventory_table_engine.sv
// inventory table engine: a compact ordered table of item key, on-hand and
// needed quantities, held in one synchronous memory with a registered read port.
// command channel: a word is taken when start is high and busy is low; busy
// stays high until the whole operation, including any table rewrite, is done.
// result channel: each result word sits on the rsp_ ports for one cycle,
// marked by rsp_strobe; rsp_last flags the final word of an operation. the
// receiver cannot stall, so results are never held back.
// per operation, with n entries in the table and row p the entry touched:
//   find, add, reduce, duplicate insert: a search of rows 0 to p in turn
//   insert of a new key, key not found: a search of all n rows, and a new
//   key is written at row n; insert into a full table: no search
//   remove: result as find, then busy while each later entry moves down one row
//   read row: one memory read, or none when the row is out of range
//   ship: one compare per row, compaction in place
//   sort: bubble passes, each one row shorter than the last
// one operation at a time: the next word can be taken at the edge that ends
// the cycle of the last result word, but after a remove only once the table rewrite is done.
// reset empties the table (fill count to zero) and returns the sequencer to
// idle; table contents are not cleared, rows past the fill count are unused.
module inventory_table_engine
   import ite_pkg::*;
#(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [FUNC_W-1:0]  req_func,
   input  logic [KEY_W-1:0]   req_item_key,
   input  logic [QTY_W-1:0]   req_on_hand,
   input  logic [QTY_W-1:0]   req_needed,
   input  logic [QTY_W-1:0]   req_amount,
   input  logic [ROW_W-1:0]   req_row,
   output logic               rsp_strobe,
   output logic [STAT_W-1:0]  rsp_status,
   output logic [ROW_W-1:0]   rsp_found_row,
   output logic [KEY_W-1:0]   rsp_out_key,
   output logic [QTY_W-1:0]   rsp_out_on_hand,
   output logic [QTY_W-1:0]   rsp_out_needed,
   output logic [TOTAL_W-1:0] rsp_entry_total,
   output logic               rsp_last
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);
   localparam logic [CW-1:0] TWO_C = CW'(2);

   state_type state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   entry_type carry_ff, carry_in;
   entry_type pend_ff, pend_in;
   logic [AW-1:0] pend_row_ff, pend_row_in;
   logic pend_valid_ff, pend_valid_in;

   func_type func_ff, func_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic [QTY_W-1:0] on_hand_ff, on_hand_in;
   logic [QTY_W-1:0] needed_ff, needed_in;
   logic [QTY_W-1:0] amount_ff, amount_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic rsp_strobe_ff, rsp_strobe_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [ROW_W-1:0] rsp_found_row_ff, rsp_found_row_in;
   entry_type rsp_entry_ff, rsp_entry_in;
   logic [TOTAL_W-1:0] rsp_entry_total_ff, rsp_entry_total_in;
   logic rsp_last_ff, rsp_last_in;

   logic mem_wr_en;
   logic [AW-1:0] mem_wr_addr;
   entry_type mem_wr_data;
   logic [AW-1:0] mem_rd_addr;
   entry_type rdata;

   logic [QTY_W:0] add_sum;
   logic [CW-1:0] idx_p1;
   logic [CW-1:0] idx_p2;

   ite_table #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (rdata)
   );

   // strict compare keeps equal shortfalls in order
   function automatic logic short_less(entry_type a, entry_type b);
      logic signed [QTY_W+1:0] sa;
      logic signed [QTY_W+1:0] sb;
      sa = signed'({2'b00, a.need}) - signed'({2'b00, a.have});
      sb = signed'({2'b00, b.need}) - signed'({2'b00, b.have});
      return sa < sb;
   endfunction

   assign add_sum = {1'b0, rdata.have} + {1'b0, amount_ff};
   assign idx_p1  = idx_ff + ONE_C;
   assign idx_p2  = idx_ff + TWO_C;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      idx_in        = idx_ff;
      wr_in         = wr_ff;
      cnt_in        = cnt_ff;
      carry_in      = carry_ff;
      pend_in       = pend_ff;
      pend_row_in   = pend_row_ff;
      pend_valid_in = pend_valid_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      on_hand_in    = on_hand_ff;
      needed_in     = needed_ff;
      amount_in     = amount_ff;
      row_in        = row_ff;

      rsp_strobe_in      = 1'b0;
      rsp_status_in      = ST_OK;
      rsp_found_row_in   = '0;
      rsp_entry_in       = '0;
      rsp_entry_total_in = TOTAL_W'(fill_ff);
      rsp_last_in        = 1'b1;

      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[AW-1:0];
      mem_wr_data = rdata;
      mem_rd_addr = idx_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               func_in    = func_type'(req_func);
               key_in     = req_item_key;
               on_hand_in = req_on_hand;
               needed_in  = req_needed;
               amount_in  = req_amount;
               row_in     = req_row;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            idx_in = '0;
            case (func_ff)
               FN_INSERT: begin
                  if (fill_ff == CAP_C) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_FULL;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_SRCH_RD;
                  end
               end
               FN_FIND, FN_REMOVE, FN_ADD, FN_REDUCE: begin
                  state_in = S_SRCH_RD;
               end
               FN_SORT: begin
                  if (fill_ff < TWO_C) begin
                     rsp_strobe_in = 1'b1;
                     state_in      = S_IDLE;
                  end else begin
                     wr_in    = fill_ff - ONE_C;
                     state_in = S_SORT_RD0;
                  end
               end
               FN_SHIP: begin
                  wr_in         = '0;
                  cnt_in        = '0;
                  pend_valid_in = 1'b0;
                  state_in      = S_SHIP_RD;
               end
               FN_READ: begin
                  if (CW'(row_ff) >= fill_ff || {1'b0, row_ff} >= (ROW_W+1)'(CAPACITY)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = ST_NOT_FOUND;
                     state_in      = S_IDLE;
                  end else begin
                     mem_rd_addr = row_ff[AW-1:0];
                     state_in    = S_ROW_OUT;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SRCH_RD: begin
            if (idx_ff == fill_ff) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
               if (func_ff == FN_INSERT) begin
                  mem_wr_en          = 1'b1;
                  mem_wr_addr        = fill_ff[AW-1:0];
                  mem_wr_data        = '{key: key_ff, have: on_hand_ff, need: needed_ff};
                  rsp_found_row_in   = ROW_W'(fill_ff);
                  rsp_entry_in       = '{key: key_ff, have: on_hand_ff, need: needed_ff};
                  rsp_entry_total_in = TOTAL_W'(fill_ff + ONE_C);
                  fill_in            = fill_ff + ONE_C;
               end else begin
                  rsp_status_in = ST_NOT_FOUND;
               end
            end else begin
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (rdata.key == key_ff) begin
               rsp_strobe_in    = 1'b1;
               rsp_found_row_in = ROW_W'(idx_ff);
               rsp_entry_in     = rdata;
               state_in         = S_IDLE;
               case (func_ff)
                  FN_INSERT: begin
                     rsp_status_in    = ST_DUPLICATE;
                     rsp_found_row_in = '0;
                     rsp_entry_in     = '0;
                  end
                  FN_REMOVE: begin
                     rsp_entry_total_in = TOTAL_W'(fill_ff - ONE_C);
                     state_in           = S_SHIFT_RD;
                  end
                  FN_ADD: begin
                     if (rdata.have == rdata.need) begin
                        rsp_status_in = ST_NONE;
                     end else if (amount_ff == '0 || amount_ff > rdata.need) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        mem_wr_en         = 1'b1;
                        mem_wr_data.have  = add_sum[QTY_W] ? '1 : add_sum[QTY_W-1:0];
                        rsp_entry_in.have = mem_wr_data.have;
                     end
                  end
                  FN_REDUCE: begin
                     if (rdata.have == '0) begin
                        rsp_status_in = ST_NONE;
                     end else if (amount_ff == '0 || amount_ff > rdata.have) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        mem_wr_en         = 1'b1;
                        mem_wr_data.have  = rdata.have - amount_ff;
                        rsp_entry_in.have = mem_wr_data.have;
                     end
                  end
                  default: begin
                  end
               endcase
               if (rsp_status_in != ST_OK) begin
                  rsp_found_row_in = '0;
                  rsp_entry_in     = '0;
               end
            end else begin
               idx_in   = idx_p1;
               state_in = S_SRCH_RD;
            end
         end
         S_SHIFT_RD: begin
            if (idx_p1 < fill_ff) begin
               mem_rd_addr = idx_p1[AW-1:0];
               state_in    = S_SHIFT_WR;
            end else begin
               fill_in  = fill_ff - ONE_C;
               state_in = S_IDLE;
            end
         end
         S_SHIFT_WR: begin
            mem_wr_en = 1'b1;
            idx_in    = idx_p1;
            state_in  = S_SHIFT_RD;
         end
         S_ROW_OUT: begin
            rsp_strobe_in    = 1'b1;
            rsp_found_row_in = row_ff;
            rsp_entry_in     = rdata;
            state_in         = S_IDLE;
         end
         S_SORT_RD0: begin
            idx_in      = '0;
            mem_rd_addr = '0;
            state_in    = S_SORT_LD0;
         end
         S_SORT_LD0: begin
            carry_in    = rdata;
            mem_rd_addr = idx_p1[AW-1:0];
            state_in    = S_SORT_STEP;
         end
         S_SORT_STEP: begin
            // the smaller-shortfall side of the pair moves on as the carry
            mem_wr_en = 1'b1;
            if (short_less(carry_ff, rdata)) begin
               mem_wr_data = rdata;
            end else begin
               mem_wr_data = carry_ff;
               carry_in    = rdata;
            end
            idx_in = idx_p1;
            if (idx_p1 == wr_ff) begin
               state_in = S_SORT_TAIL;
            end else begin
               mem_rd_addr = idx_p2[AW-1:0];
            end
         end
         S_SORT_TAIL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = wr_ff[AW-1:0];
            mem_wr_data = carry_ff;
            wr_in       = wr_ff - ONE_C;
            if (wr_ff == ONE_C) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               state_in = S_SORT_RD0;
            end
         end
         S_SHIP_RD: begin
            if (idx_ff == fill_ff) begin
               state_in = S_SHIP_END;
            end else begin
               state_in = S_SHIP_CMP;
            end
         end
         S_SHIP_CMP: begin
            // a shipped word is held back one hit so the final one carries last
            if (rdata.have == rdata.need) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in      = 1'b1;
                  rsp_found_row_in   = ROW_W'(pend_row_ff);
                  rsp_entry_in       = pend_ff;
                  rsp_entry_total_in = TOTAL_W'(cnt_ff);
                  rsp_last_in        = 1'b0;
               end
               pend_in       = rdata;
               pend_row_in   = idx_ff[AW-1:0];
               pend_valid_in = 1'b1;
               cnt_in        = cnt_ff + ONE_C;
            end else begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = wr_ff[AW-1:0];
               wr_in       = wr_ff + ONE_C;
            end
            idx_in   = idx_p1;
            state_in = S_SHIP_RD;
         end
         S_SHIP_END: begin
            fill_in       = wr_ff;
            rsp_strobe_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_found_row_in   = ROW_W'(pend_row_ff);
               rsp_entry_in       = pend_ff;
               rsp_entry_total_in = TOTAL_W'(cnt_ff);
            end else begin
               rsp_status_in      = ST_NONE;
               rsp_entry_total_in = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff             <= idx_in;
      wr_ff              <= wr_in;
      cnt_ff             <= cnt_in;
      carry_ff           <= carry_in;
      pend_ff            <= pend_in;
      pend_row_ff        <= pend_row_in;
      func_ff            <= func_in;
      key_ff             <= key_in;
      on_hand_ff         <= on_hand_in;
      needed_ff          <= needed_in;
      amount_ff          <= amount_in;
      row_ff             <= row_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_found_row_ff   <= rsp_found_row_in;
      rsp_entry_ff       <= rsp_entry_in;
      rsp_entry_total_ff <= rsp_entry_total_in;
      rsp_last_ff        <= rsp_last_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_row   = rsp_found_row_ff;
   assign rsp_out_key     = rsp_entry_ff.key;
   assign rsp_out_on_hand = rsp_entry_ff.have;
   assign rsp_out_needed  = rsp_entry_ff.need;
   assign rsp_entry_total = rsp_entry_total_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
